@@ sv/swcc_pkg.sv @@
// Package for the sliding-window cross-correlator.
// Holds the sizes, sample and sum types, register codes and the cell control struct.
// Has no dependencies; every other file imports it.
package swcc_pkg;

    // Largest window and largest lag that the cell row supports.
    localparam int WINDOW_MAX = 64;
    localparam int LAG_MAX    = 64;

    // One cell per history slot; both delay lines share the row.
    localparam int CELL_COUNT = (WINDOW_MAX > LAG_MAX) ? WINDOW_MAX : LAG_MAX;

    // Field and register widths.
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = 32;
    localparam int SUM_W    = 38;
    localparam int CFG_W    = 7;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;

    // Register indexes, taken from the word address bit.
    localparam logic REG_WINDOW_LEN = 1'b0;
    localparam logic REG_LAG_BACK   = 1'b1;

    // Register reset values.
    localparam logic [CFG_W-1:0] WINDOW_LEN_RESET = 7'd3;
    localparam logic [CFG_W-1:0] LAG_BACK_RESET   = 7'd0;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic clear;    // restart: all history goes to zero
        logic b_shift;  // a sample pair is accepted
        logic p_shift;  // a product enters the window
    } swcc_ctrl_t;

endpackage

@@ sv/swcc_cell.sv @@
// One cell of the history row of the sliding-window cross-correlator.
// Holds one slot of the b delay line and one slot of the product delay line.
// Depends on swcc_pkg.
module swcc_cell
    import swcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  swcc_ctrl_t ctrl,
    input  logic       b_sel,
    input  sample_t    b_new,
    input  sample_t    b_in,
    output sample_t    b_out,
    input  logic       p_sel,
    input  prod_t      p_new,
    input  prod_t      p_in,
    output prod_t      p_out
);

    sample_t b_reg, b_next;
    prod_t   p_reg, p_next;

    // A selected cell takes the new value; the others take their upper neighbor's.
    always_comb begin
        b_next = b_reg;
        p_next = p_reg;
        if (ctrl.clear) begin
            b_next = '0;
            p_next = '0;
        end else begin
            if (ctrl.b_shift) begin
                b_next = b_sel ? b_new : b_in;
            end
            if (ctrl.p_shift) begin
                p_next = p_sel ? p_new : p_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg <= '0;
            p_reg <= '0;
        end else begin
            b_reg <= b_next;
            p_reg <= p_next;
        end
    end

    assign b_out = b_reg;
    assign p_out = p_reg;

endmodule

@@ sv/swcc_cfg.sv @@
// Configuration registers of the sliding-window cross-correlator.
// APB-style register file, clamping of window and lag, and the cell select decode.
// Depends on swcc_pkg.
module swcc_cfg
    import swcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic [CELL_COUNT-1:0] p_sel,
    output logic [CELL_COUNT-1:0] b_sel,
    output logic                  lag_zero,
    output logic                  restart
);

    logic [CFG_W-1:0] window_len_reg, window_len_next;
    logic [CFG_W-1:0] lag_back_reg, lag_back_next;
    logic [CFG_W-1:0] k_eff;
    logic [CFG_W-1:0] lag_eff;
    logic             reg_idx;

    assign reg_idx = paddr[ADDR_W-1];
    assign restart = psel && penable && pwrite;

    // Register write decode; any write restarts the stream.
    always_comb begin
        window_len_next = window_len_reg;
        lag_back_next   = lag_back_reg;
        if (restart) begin
            unique case (reg_idx)
                REG_WINDOW_LEN: window_len_next = pwdata[CFG_W-1:0];
                REG_LAG_BACK:   lag_back_next   = pwdata[CFG_W-1:0];
                default:        window_len_next = window_len_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_LEN_RESET;
            lag_back_reg   <= LAG_BACK_RESET;
        end else begin
            window_len_reg <= window_len_next;
            lag_back_reg   <= lag_back_next;
        end
    end

    // Read data.
    always_comb begin
        unique case (reg_idx)
            REG_WINDOW_LEN: prdata = DATA_W'(window_len_reg);
            REG_LAG_BACK:   prdata = DATA_W'(lag_back_reg);
            default:        prdata = '0;
        endcase
    end

    // Clamp the window to 1..WINDOW_MAX and the lag to 0..LAG_MAX.
    always_comb begin
        k_eff = window_len_reg;
        if (window_len_reg == '0) begin
            k_eff = CFG_W'(1);
        end else if (32'(window_len_reg) > WINDOW_MAX) begin
            k_eff = CFG_W'(WINDOW_MAX);
        end
        lag_eff = lag_back_reg;
        if (32'(lag_back_reg) > LAG_MAX) begin
            lag_eff = CFG_W'(LAG_MAX);
        end
    end

    // A value written into cell i comes out of cell 0 i+1 beats later.
    always_comb begin
        for (int i = 0; i < CELL_COUNT; i++) begin
            p_sel[i] = (32'(k_eff) == 32'(i + 1));
            b_sel[i] = (32'(lag_eff) == 32'(i + 1));
        end
    end

    assign lag_zero = (lag_eff == '0);

endmodule

@@ sv/sliding_window_cross_correlator.sv @@
// Sliding-window cross-correlator: for each accepted sample pair (a, b) it returns the exact
// sum of a_i * b_(i-lag_back) over the last window_len pairs, as a 38-bit signed beat. It takes
// one pair per clock cycle when the result side keeps up; a result passes through the 16x16
// multiplier register and then the accumulator register before it leaves. The
// b and product histories live in a row of CELL_COUNT cells that shift once per beat; a new
// value is written straight into the cell that brings it out of the row end after exactly lag
// or window beats, so no wide read mux is needed. Any register write restarts the stream and
// clears all history in the same cycle; write registers only while no beat is in flight.
// Register map: window_len at byte 0, lag_back at byte 4.
module sliding_window_cross_correlator
    import swcc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              s_valid,
    output logic              s_ready,
    input  sample_t           s_sample_a,
    input  sample_t           s_sample_b,
    output logic              m_valid,
    input  logic              m_ready,
    output sum_t              m_window_sum
);

    logic [CELL_COUNT-1:0] p_sel;
    logic [CELL_COUNT-1:0] b_sel;
    logic                  lag_zero;
    logic                  restart;
    swcc_ctrl_t            ctrl;

    sample_t b_tap [0:CELL_COUNT];
    prod_t   p_tap [0:CELL_COUNT];

    logic    accept;
    logic    s2_adv;
    sample_t lagged_b;
    prod_t   prod_reg, prod_next;
    logic    p_valid_reg, p_valid_next;
    logic    m_valid_reg, m_valid_next;
    sum_t    sum_reg, sum_next;

    assign pready = 1'b1;

    swcc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .p_sel    (p_sel),
        .b_sel    (b_sel),
        .lag_zero (lag_zero),
        .restart  (restart)
    );

    // Handshake: the product stage moves on when the output register is free or being taken.
    assign s2_adv  = p_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p_valid_reg || s2_adv;
    assign accept  = s_valid && s_ready;

    assign ctrl.clear   = restart;
    assign ctrl.b_shift = accept;
    assign ctrl.p_shift = s2_adv;

    // History row; the top cell is fed zeros.
    assign b_tap[CELL_COUNT] = '0;
    assign p_tap[CELL_COUNT] = '0;

    for (genvar g = 0; g < CELL_COUNT; g++) begin : g_cell
        swcc_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .b_sel   (b_sel[g]),
            .b_new   (s_sample_b),
            .b_in    (b_tap[g+1]),
            .b_out   (b_tap[g]),
            .p_sel   (p_sel[g]),
            .p_new   (prod_reg),
            .p_in    (p_tap[g+1]),
            .p_out   (p_tap[g])
        );
    end

    // Multiplier stage: with no lag the current b is used directly.
    assign lagged_b  = lag_zero ? s_sample_b : b_tap[0];
    assign prod_next = prod_t'(s_sample_a) * prod_t'(lagged_b);

    always_ff @(posedge aclk) begin
        if (accept) begin
            prod_reg <= prod_next;
        end
    end

    // Accumulator stage: add the new product, drop the one leaving the window.
    always_comb begin
        p_valid_next = p_valid_reg;
        m_valid_next = m_valid_reg;
        sum_next     = sum_reg;
        if (restart) begin
            sum_next = '0;
        end else if (s2_adv) begin
            sum_next = sum_reg + sum_t'(prod_reg) - sum_t'(p_tap[0]);
        end
        if (accept) begin
            p_valid_next = 1'b1;
        end else if (s2_adv) begin
            p_valid_next = 1'b0;
        end
        if (s2_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            sum_reg     <= '0;
        end else begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
            sum_reg     <= sum_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_window_sum = sum_reg;

    // A restart leaves the running sum at zero.
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> (sum_reg == '0))
        else $error("running sum not cleared after register write");

    // Exactly one cell receives each new product.
    a_window_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(p_sel))
        else $error("window select is not one-hot");

    // With a lag, exactly one cell receives each new b sample.
    a_lag_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        lag_zero || $onehot(b_sel))
        else $error("lag select is not one-hot");

    // Both stages full and the output stalled: no new pair may enter.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (p_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("pair accepted while pipeline is full");

endmodule
